// ===== sv/gbpe_pkg.sv =====
// gbpe_pkg: types, constants and the natural-log table of the bit-propagation estimator.
// No dependencies; imported by graph_bit_propagation_estimator_core.
package gbpe_pkg;

	localparam int NODES     = 4096;
	localparam int CODE_BITS = 64;
	localparam int NODE_W    = $clog2(NODES);
	localparam int K_W       = $clog2(CODE_BITS + 1);
	localparam int ROM_IW    = $clog2(CODE_BITS);
	localparam int LN_W      = 20;
	localparam int PROD_W    = LN_W + 32;
	localparam logic [63:0] LN2_Q32 = 64'd2977044472;

	typedef enum logic [2:0] {
		FN_LOAD   = 3'd0,
		FN_EDGE   = 3'd1,
		FN_REMOTE = 3'd2,
		FN_CLOSE  = 3'd3,
		FN_EST    = 3'd4
	} func_t;

	typedef enum logic {
		REG_SCALE = 1'b0,
		REG_LIMIT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [2:0]  func;
		logic [11:0] node_index;
		logic [11:0] source_index;
		logic [63:0] vector_bits;
		logic        has_prior;
		logic [31:0] prior_estimate;
	} item_t;

	typedef struct packed {
		logic [31:0] estimate;
		logic        accepted;
		logic        singular;
		logic [15:0] round_number;
		logic [11:0] node_out;
	} result_t;

	typedef logic [LN_W-1:0] ln_rom_t [CODE_BITS];

	// log2(x) in Q8.24 by repeated squaring of the normalized mantissa
	function automatic logic [31:0] log2_q24(input int x);
		int          top;
		logic [63:0] y;
		logic [23:0] frac;
		top  = 0;
		frac = '0;
		for (int i = 1; i < 32; i++) begin
			if ((x >> i) != 0) top = i;
		end
		y = (64'(x) << 30) >> top;
		for (int i = 0; i < 24; i++) begin
			y    = (y * y) >> 30;
			frac = {frac[22:0], 1'b0};
			if (y >= (64'd1 << 31)) begin
				frac[0] = 1'b1;
				y       = y >> 1;
			end
		end
		return (32'(top) << 24) | 32'(frac);
	endfunction

	// -ln(1 - k/N) in Q4.16 for every popcount below N
	function automatic ln_rom_t build_ln_rom();
		ln_rom_t     rom;
		logic [63:0] d;
		logic [63:0] p;
		for (int k = 0; k < CODE_BITS; k++) begin
			d      = 64'(log2_q24(CODE_BITS)) - 64'(log2_q24(CODE_BITS - k));
			p      = (d * LN2_Q32 + (64'd1 << 39)) >> 40;
			rom[k] = p[LN_W-1:0];
		end
		return rom;
	endfunction

	localparam ln_rom_t LN_ROM = build_ln_rom();

endpackage

// ===== sv/graph_bit_propagation_estimator_core.sv =====
// graph_bit_propagation_estimator_core: seed/previous/next bit-vector stores and estimator.
// Depends on gbpe_pkg for types, sizes and the natural-log table.
// Sequence: load writes all three stores on acceptance (busy stays low); edge and remote pass
// through the read-modify-write state; estimate passes EST1, EST2 and EST3 and strobes its result
// from EST3 before it takes the next word; close round sweeps every node of the stores, then drains.
// One item at a time: busy is high while an item is at work, each memory has one write port.
// Reset clears control state, round counter and configuration registers; the stores stay undefined until
// loaded. The receiver cannot stall: result_valid pulses one cycle with the result word.
module graph_bit_propagation_estimator_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  gbpe_pkg::item_t   item,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [31:0]       cfg_data,
	output logic              result_valid,
	output gbpe_pkg::result_t result
);
	import gbpe_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RMW,
		S_EST1,
		S_EST2,
		S_EST3,
		S_SWEEP,
		S_DRAIN
	} state_t;

	state_t state_q;

	// three stores, one read and one write port each
	logic [CODE_BITS-1:0] seed_mem [NODES];
	logic [CODE_BITS-1:0] prev_mem [NODES];
	logic [CODE_BITS-1:0] next_mem [NODES];

	logic [CODE_BITS-1:0] seed_rd_q, prev_rd_q, next_rd_q;
	logic [NODE_W-1:0]    seed_ra, prev_ra, next_ra;
	logic                 seed_we, prev_we, next_we;
	logic [NODE_W-1:0]    seed_wa, prev_wa, next_wa;
	logic [CODE_BITS-1:0] seed_wd, prev_wd, next_wd;

	logic [31:0]       scale_q;
	logic [6:0]        limit_q;
	logic [15:0]       round_q;
	item_t             item_q;
	logic [NODE_W-1:0] cnt_q;
	logic              sw_vld_s1;
	logic [NODE_W-1:0] sw_addr_s1;
	logic [K_W-1:0]    k_s2;
	logic [PROD_W-1:0] prod_s3;
	logic [K_W-1:0]    k_s3;
	logic              result_valid_q;
	result_t           result_q;

	logic                 accept;
	logic                 node_ok, src_ok;
	logic [CODE_BITS-1:0] in_bits;
	logic [NODE_W-1:0]    node_a, src_a, node_q_a;
	logic [K_W-1:0]       pop;

	assign accept   = start && (state_q == S_IDLE);
	assign node_ok  = 32'(item.node_index) < NODES;
	assign src_ok   = 32'(item.source_index) < NODES;
	assign in_bits  = item.vector_bits[CODE_BITS-1:0];
	assign node_a   = item.node_index[NODE_W-1:0];
	assign src_a    = item.source_index[NODE_W-1:0];
	assign node_q_a = item_q.node_index[NODE_W-1:0];

	// popcount of the previous-round word
	always_comb begin
		pop = '0;
		for (int i = 0; i < CODE_BITS; i++) pop = pop + K_W'(prev_rd_q[i]);
	end

	// memory port steering
	always_comb begin
		seed_ra = cnt_q;
		next_ra = cnt_q;
		prev_ra = node_a;
		seed_we = 1'b0; prev_we = 1'b0; next_we = 1'b0;
		seed_wa = node_a; prev_wa = node_a; next_wa = node_a;
		seed_wd = in_bits; prev_wd = in_bits; next_wd = in_bits;
		if (state_q == S_IDLE) begin
			next_ra = node_a;
			if (item.func == FN_EDGE) prev_ra = src_a;
			if (accept && item.func == FN_LOAD && node_ok) begin
				seed_we = 1'b1; prev_we = 1'b1; next_we = 1'b1;
			end
		end else if (state_q == S_RMW) begin
			next_we = 1'b1;
			next_wa = node_q_a;
			next_wd = next_rd_q | ((item_q.func == FN_EDGE) ? prev_rd_q
				: item_q.vector_bits[CODE_BITS-1:0]);
		end else if (sw_vld_s1) begin
			// advance the round: previous takes next, next takes seed
			prev_we = 1'b1; next_we = 1'b1;
			prev_wa = sw_addr_s1; next_wa = sw_addr_s1;
			prev_wd = next_rd_q; next_wd = seed_rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (seed_we) seed_mem[seed_wa] <= seed_wd;
		seed_rd_q <= seed_mem[seed_ra];
	end

	always_ff @(posedge clk) begin
		if (prev_we) prev_mem[prev_wa] <= prev_wd;
		prev_rd_q <= prev_mem[prev_ra];
	end

	always_ff @(posedge clk) begin
		if (next_we) next_mem[next_wa] <= next_wd;
		next_rd_q <= next_mem[next_ra];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= 32'd65536;
			limit_q <= 7'd40;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_SCALE: scale_q <= cfg_data;
				REG_LIMIT: limit_q <= cfg_data[6:0];
				default:   scale_q <= scale_q;
			endcase
		end
	end

	// estimate arithmetic for the final stage
	logic [PROD_W-16:0] est_rnd;
	logic [31:0]        est_sat;
	logic [32:0]        est_avg;
	logic               acc_c, sing_c;

	assign est_rnd = (PROD_W-15)'((prod_s3 + PROD_W'(32768)) >> 16);
	assign est_sat = (est_rnd > (PROD_W-15)'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : est_rnd[31:0];
	assign est_avg = (33'(est_sat) + 33'(item_q.prior_estimate)) >> 1;
	assign sing_c  = (32'(k_s3) == CODE_BITS);
	assign acc_c   = (7'(k_s3) <= limit_q);

	// sequencer with registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			round_q        <= '0;
			cnt_q          <= '0;
			sw_vld_s1      <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						item_q <= item;
						case (func_t'(item.func))
							FN_EDGE:   if (node_ok && src_ok) state_q <= S_RMW;
							FN_REMOTE: if (node_ok) state_q <= S_RMW;
							FN_EST:    if (node_ok) state_q <= S_EST1;
							FN_CLOSE: begin
								cnt_q   <= '0;
								state_q <= S_SWEEP;
							end
							default:   state_q <= S_IDLE;
						endcase
					end
				end
				S_RMW: state_q <= S_IDLE;
				S_EST1: begin
					k_s2    <= pop;
					state_q <= S_EST2;
				end
				S_EST2: begin
					k_s3    <= k_s2;
					prod_s3 <= PROD_W'(LN_ROM[k_s2[ROM_IW-1:0]]) * PROD_W'(scale_q);
					state_q <= S_EST3;
				end
				S_EST3: begin
					result_q.estimate     <= sing_c ? 32'd0
						: ((acc_c && item_q.has_prior) ? est_avg[31:0] : est_sat);
					result_q.accepted     <= acc_c;
					result_q.singular     <= sing_c;
					result_q.round_number <= round_q;
					result_q.node_out     <= item_q.node_index;
					result_valid_q        <= 1'b1;
					state_q               <= S_IDLE;
				end
				S_SWEEP: begin
					sw_vld_s1  <= 1'b1;
					sw_addr_s1 <= cnt_q;
					cnt_q      <= cnt_q + 1'b1;
					if (32'(cnt_q) == NODES - 1) state_q <= S_DRAIN;
				end
				S_DRAIN: begin
					sw_vld_s1 <= 1'b0;
					round_q   <= round_q + 16'd1;
					state_q   <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// a result word only follows the last estimate stage
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> $past(state_q == S_EST2, 2)) else $error("stray result");

	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && result_q.singular) |-> (result_q.estimate == 32'd0))
		else $error("singular estimate not zero");

	a_round_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_DRAIN) |=> $stable(round_q)) else $error("round moved outside close");

	a_sweep_write: assert property (@(posedge clk) disable iff (!arst_n)
		sw_vld_s1 |-> (state_q == S_SWEEP || state_q == S_DRAIN))
		else $error("sweep write outside close");

endmodule
